### rtl/sad_pkg.sv
`timescale 1ns / 1ps
// Shared codes for the address header decoder: result kinds, status codes,
// register indexes, field lengths and reset type codes. No dependencies.
package sad_pkg;

   localparam logic [1:0] KIND_NAME = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_BADADDR   = 2'd2;

   localparam logic [1:0] CSR_IPV4_CODE   = 2'd0;
   localparam logic [1:0] CSR_DOMAIN_CODE = 2'd1;
   localparam logic [1:0] CSR_IPV6_CODE   = 2'd2;

   localparam logic [7:0] IPV4_ADDR_BYTES = 8'd4;
   localparam logic [7:0] IPV6_ADDR_BYTES = 8'd16;
   localparam logic [7:0] PORT_BYTES      = 8'd2;

   localparam logic [15:0] IPV4_MIN_LEN   = 16'd7;
   localparam logic [15:0] IPV6_MIN_LEN   = 16'd19;
   localparam logic [15:0] DOMAIN_MIN_LEN = 16'd2;

   localparam logic [8:0] DOMAIN_OVERHEAD = 9'd3;

   localparam logic [7:0] RESET_IPV4_CODE   = 8'd1;
   localparam logic [7:0] RESET_DOMAIN_CODE = 8'd3;
   localparam logic [7:0] RESET_IPV6_CODE   = 8'd4;

endpackage

### rtl/socks_address_decoder.sv
`timescale 1ns / 1ps
// Byte-serial decoder for a SOCKS5-style address header.
// Depends on sad_pkg for result kinds, status codes and register indexes.
//
// Takes one byte word per clock and gives at most one result word per byte.
// Every byte is parsed in the cycle it is accepted: the parser registers
// (phase, address and port shifters, counters) update at that edge and any
// result lands in a single output register, so the sustained rate is one
// byte per cycle. req_ready is high while the output register is empty or
// being taken in the same cycle, so it follows rsp_ready combinationally.
// Domain name bytes come out as they arrive; the last port byte yields the
// completion word; a length fault or unknown type yields one error word and
// the parser then ignores bytes until the next req_first_byte. The user
// must write type codes through the csr_ port while no header is in flight.
module socks_address_decoder
   import sad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic [15:0] req_total_len,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_address_type,
   output logic [63:0] rsp_address_high,
   output logic [63:0] rsp_address_low,
   output logic [15:0] rsp_port_number,
   output logic [7:0]  rsp_name_length,
   output logic [8:0]  rsp_bytes_consumed,
   output logic [7:0]  rsp_name_byte,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ADDR,
      PH_DLEN,
      PH_DNAME,
      PH_PORT
   } phase_type;

   logic [7:0]  ipv4_code_ff, domain_code_ff, ipv6_code_ff;

   phase_type   phase_ff, phase_in;
   logic [7:0]  htype_ff, htype_in;
   logic [63:0] addr_hi_ff, addr_hi_in;
   logic [63:0] addr_lo_ff, addr_lo_in;
   logic [15:0] port_ff, port_in;
   logic [7:0]  dlen_ff, dlen_in;
   logic [7:0]  remain_ff, remain_in;
   logic [15:0] left_ff, left_in;
   logic [8:0]  consumed_ff, consumed_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  otype_ff, otype_in;
   logic [63:0] ohi_ff, ohi_in;
   logic [63:0] olo_ff, olo_in;
   logic [15:0] oport_ff, oport_in;
   logic [7:0]  olen_ff, olen_in;
   logic [8:0]  ocons_ff, ocons_in;
   logic [7:0]  obyte_ff, obyte_in;

   logic        req_fire;
   logic        has_result;
   logic [7:0]  remain_dec;
   logic [15:0] left_dec;
   logic [8:0]  consumed_inc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign remain_dec   = (remain_ff != 8'd0) ? remain_ff - 8'd1 : 8'd0;
   assign left_dec     = (left_ff != 16'd0) ? left_ff - 16'd1 : 16'd0;
   assign consumed_inc = consumed_ff + 9'd1;

   always_comb begin
      phase_in    = phase_ff;
      htype_in    = htype_ff;
      addr_hi_in  = addr_hi_ff;
      addr_lo_in  = addr_lo_ff;
      port_in     = port_ff;
      dlen_in     = dlen_ff;
      remain_in   = remain_ff;
      left_in     = left_ff;
      consumed_in = consumed_ff;
      has_result  = 1'b0;
      kind_in     = KIND_ERR;
      status_in   = ST_OK;
      otype_in    = 8'd0;
      ohi_in      = 64'd0;
      olo_in      = 64'd0;
      oport_in    = 16'd0;
      olen_in     = 8'd0;
      ocons_in    = 9'd0;
      obyte_in    = 8'd0;

      if (req_first_byte) begin
         htype_in    = 8'd0;
         addr_hi_in  = 64'd0;
         addr_lo_in  = 64'd0;
         port_in     = 16'd0;
         dlen_in     = 8'd0;
         remain_in   = 8'd0;
         consumed_in = 9'd0;
         left_in     = req_total_len;
         phase_in    = PH_IDLE;
         if (req_total_len == 16'd0) begin
            has_result = 1'b1;
            status_in  = ST_MALFORMED;
         end else begin
            htype_in    = req_data_byte;
            otype_in    = req_data_byte;
            left_in     = req_total_len - 16'd1;
            consumed_in = 9'd1;
            if (req_data_byte == ipv4_code_ff) begin
               if (req_total_len < IPV4_MIN_LEN) begin
                  has_result = 1'b1;
                  status_in  = ST_MALFORMED;
               end else begin
                  remain_in = IPV4_ADDR_BYTES;
                  phase_in  = PH_ADDR;
               end
            end else if (req_data_byte == ipv6_code_ff) begin
               if (req_total_len < IPV6_MIN_LEN) begin
                  has_result = 1'b1;
                  status_in  = ST_MALFORMED;
               end else begin
                  remain_in = IPV6_ADDR_BYTES;
                  phase_in  = PH_ADDR;
               end
            end else if (req_data_byte == domain_code_ff) begin
               if (req_total_len < DOMAIN_MIN_LEN) begin
                  has_result = 1'b1;
                  status_in  = ST_MALFORMED;
               end else begin
                  phase_in = PH_DLEN;
               end
            end else begin
               has_result = 1'b1;
               status_in  = ST_BADADDR;
            end
         end
      end else begin
         otype_in = htype_ff;
         case (phase_ff)
            PH_ADDR: begin
               left_in     = left_dec;
               consumed_in = consumed_inc;
               addr_hi_in  = {addr_hi_ff[55:0], addr_lo_ff[63:56]};
               addr_lo_in  = {addr_lo_ff[55:0], req_data_byte};
               remain_in   = remain_dec;
               if (remain_dec == 8'd0) begin
                  remain_in = PORT_BYTES;
                  phase_in  = PH_PORT;
               end
            end
            PH_DLEN: begin
               left_in     = left_dec;
               consumed_in = consumed_inc;
               dlen_in     = req_data_byte;
               if (req_data_byte == 8'd0 ||
                   {1'b0, left_ff} < ({9'd0, req_data_byte} + {8'd0, DOMAIN_OVERHEAD})) begin
                  has_result = 1'b1;
                  status_in  = ST_BADADDR;
                  phase_in   = PH_IDLE;
               end else begin
                  remain_in = req_data_byte;
                  phase_in  = PH_DNAME;
               end
            end
            PH_DNAME: begin
               left_in     = left_dec;
               consumed_in = consumed_inc;
               has_result  = 1'b1;
               kind_in     = KIND_NAME;
               olen_in     = dlen_ff;
               obyte_in    = req_data_byte;
               remain_in   = remain_dec;
               if (remain_dec == 8'd0) begin
                  remain_in = PORT_BYTES;
                  phase_in  = PH_PORT;
               end
            end
            PH_PORT: begin
               left_in     = left_dec;
               consumed_in = consumed_inc;
               port_in     = {port_ff[7:0], req_data_byte};
               remain_in   = remain_dec;
               if (remain_dec == 8'd0) begin
                  has_result = 1'b1;
                  kind_in    = KIND_DONE;
                  ohi_in     = addr_hi_ff;
                  olo_in     = addr_lo_ff;
                  oport_in   = {port_ff[7:0], req_data_byte};
                  olen_in    = dlen_ff;
                  ocons_in   = consumed_inc;
                  phase_in   = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = has_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ipv4_code_ff   <= RESET_IPV4_CODE;
         domain_code_ff <= RESET_DOMAIN_CODE;
         ipv6_code_ff   <= RESET_IPV6_CODE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IPV4_CODE:   ipv4_code_ff   <= csr_wdata;
            CSR_DOMAIN_CODE: domain_code_ff <= csr_wdata;
            CSR_IPV6_CODE:   ipv6_code_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         htype_ff     <= 8'd0;
         addr_hi_ff   <= 64'd0;
         addr_lo_ff   <= 64'd0;
         port_ff      <= 16'd0;
         dlen_ff      <= 8'd0;
         remain_ff    <= 8'd0;
         left_ff      <= 16'd0;
         consumed_ff  <= 9'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff    <= phase_in;
            htype_ff    <= htype_in;
            addr_hi_ff  <= addr_hi_in;
            addr_lo_ff  <= addr_lo_in;
            port_ff     <= port_in;
            dlen_ff     <= dlen_in;
            remain_ff   <= remain_in;
            left_ff     <= left_in;
            consumed_ff <= consumed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && has_result) begin
         kind_ff   <= kind_in;
         status_ff <= status_in;
         otype_ff  <= otype_in;
         ohi_ff    <= ohi_in;
         olo_ff    <= olo_in;
         oport_ff  <= oport_in;
         olen_ff   <= olen_in;
         ocons_ff  <= ocons_in;
         obyte_ff  <= obyte_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_status         = status_ff;
   assign rsp_address_type   = otype_ff;
   assign rsp_address_high   = ohi_ff;
   assign rsp_address_low    = olo_ff;
   assign rsp_port_number    = oport_ff;
   assign rsp_name_length    = olen_ff;
   assign rsp_bytes_consumed = ocons_ff;
   assign rsp_name_byte      = obyte_ff;

   a_empty_buffer_errors: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_first_byte && req_total_len == 16'd0
      |=> rsp_valid_ff && kind_ff == KIND_ERR && status_ff == ST_MALFORMED)
      else $error("empty buffer did not give a malformed error");

   a_error_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_ERR
      |-> ohi_ff == 64'd0 && olo_ff == 64'd0 && oport_ff == 16'd0 && ocons_ff == 9'd0)
      else $error("error word carries address or port data");

   a_domain_length_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_DONE && olen_ff != 8'd0
      |-> ocons_ff == {1'b0, olen_ff} + 9'd4)
      else $error("domain header length does not match bytes consumed");

   a_ip_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_DONE && olen_ff == 8'd0
      |-> ocons_ff == 9'd7 || ocons_ff == 9'd19)
      else $error("IP header completed with wrong length");

   a_name_count_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DNAME |-> remain_ff != 8'd0)
      else $error("name phase with no bytes remaining");

endmodule

### bench/socks_address_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking bench for socks_address_decoder: a directed table, then random
// headers under several type code settings, checked word by word against a
// byte-serial header predictor. Depends on sad_pkg and the decoder RTL.
module socks_address_decoder_test;
   import sad_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;

   typedef enum logic [2:0] {
      PHASE_IDLE, PHASE_ADDR, PHASE_DLEN, PHASE_DNAME, PHASE_PORT
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [7:0]  atype;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [15:0] port;
      logic [7:0]  name_len;
      logic [8:0]  consumed;
      logic [7:0]  name_byte;
   } header_word_type;

   typedef struct {
      logic [7:0]  data;
      logic        first;
      logic [15:0] total;
      bit          typed;
      logic [1:0]  status;
      logic [7:0]  atype;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_first_byte;
   logic [15:0] req_total_len;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_address_type;
   logic [63:0] rsp_address_high;
   logic [63:0] rsp_address_low;
   logic [15:0] rsp_port_number;
   logic [7:0]  rsp_name_length;
   logic [8:0]  rsp_bytes_consumed;
   logic [7:0]  rsp_name_byte;

   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   // predictor copy of the type codes and parser state
   logic [7:0]      code_ipv4   = 8'd1;
   logic [7:0]      code_domain = 8'd3;
   logic [7:0]      code_ipv6   = 8'd4;
   parse_phase_type phase       = PHASE_IDLE;
   logic [7:0]      hdr_type    = 8'd0;
   logic [63:0]     addr_high   = 64'd0;
   logic [63:0]     addr_low    = 64'd0;
   logic [15:0]     port_acc    = 16'd0;
   logic [7:0]      dom_len     = 8'd0;
   logic [7:0]      field_left  = 8'd0;
   logic [15:0]     buf_left    = 16'd0;
   logic [8:0]      byte_count  = 9'd0;

   header_word_type due_results[$];
   stim_row_type    directed_rows[$];
   header_word_type want;

   int mismatches  = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int hold_asked  = 0;
   int holds_done  = 0;
   int hold_left   = 0;
   int mode_left   = 0;
   int stall_pct   = 0;

   socks_address_decoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_first_byte     (req_first_byte),
      .req_total_len      (req_total_len),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_status         (rsp_status),
      .rsp_address_type   (rsp_address_type),
      .rsp_address_high   (rsp_address_high),
      .rsp_address_low    (rsp_address_low),
      .rsp_port_number    (rsp_port_number),
      .rsp_name_length    (rsp_name_length),
      .rsp_bytes_consumed (rsp_bytes_consumed),
      .rsp_name_byte      (rsp_name_byte),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void take_byte();
      if (buf_left != 16'd0) buf_left = buf_left - 16'd1;
      byte_count = byte_count + 9'd1;
   endfunction

   task automatic decode_header_byte(input logic [7:0] d, input logic f,
                                     input logic [15:0] t,
                                     output bit produced, output header_word_type w);
      bit         faulted;
      logic [1:0] fault;
      int         avail;
      faulted  = 1'b0;
      fault    = ST_OK;
      produced = 1'b0;
      w        = '0;
      if (f) begin
         hdr_type   = 8'd0;
         addr_high  = 64'd0;
         addr_low   = 64'd0;
         port_acc   = 16'd0;
         dom_len    = 8'd0;
         field_left = 8'd0;
         byte_count = 9'd0;
         buf_left   = t;
         phase      = PHASE_IDLE;
         if (t == 16'd0) begin
            faulted = 1'b1;
            fault   = ST_MALFORMED;
         end else begin
            hdr_type = d;
            take_byte();
            if (d == code_ipv4) begin
               if (t < 16'd7) begin
                  faulted = 1'b1;
                  fault   = ST_MALFORMED;
               end else begin
                  field_left = 8'd4;
                  phase      = PHASE_ADDR;
               end
            end else if (d == code_ipv6) begin
               if (t < 16'd19) begin
                  faulted = 1'b1;
                  fault   = ST_MALFORMED;
               end else begin
                  field_left = 8'd16;
                  phase      = PHASE_ADDR;
               end
            end else if (d == code_domain) begin
               if (t < 16'd2) begin
                  faulted = 1'b1;
                  fault   = ST_MALFORMED;
               end else begin
                  phase = PHASE_DLEN;
               end
            end else begin
               faulted = 1'b1;
               fault   = ST_BADADDR;
            end
         end
      end else begin
         case (phase)
            PHASE_ADDR: begin
               take_byte();
               {addr_high, addr_low} = {addr_high[55:0], addr_low, d};
               if (field_left != 8'd0) field_left = field_left - 8'd1;
               if (field_left == 8'd0) begin
                  field_left = 8'd2;
                  phase      = PHASE_PORT;
               end
            end
            PHASE_DLEN: begin
               avail = int'(buf_left);
               take_byte();
               dom_len = d;
               if (d == 8'd0 || avail < int'(d) + 3) begin
                  faulted = 1'b1;
                  fault   = ST_BADADDR;
               end else begin
                  field_left = d;
                  phase      = PHASE_DNAME;
               end
            end
            PHASE_DNAME: begin
               take_byte();
               produced    = 1'b1;
               w.kind      = KIND_NAME;
               w.status    = ST_OK;
               w.atype     = hdr_type;
               w.name_len  = dom_len;
               w.name_byte = d;
               if (field_left != 8'd0) field_left = field_left - 8'd1;
               if (field_left == 8'd0) begin
                  field_left = 8'd2;
                  phase      = PHASE_PORT;
               end
            end
            PHASE_PORT: begin
               take_byte();
               port_acc = {port_acc[7:0], d};
               if (field_left != 8'd0) field_left = field_left - 8'd1;
               if (field_left == 8'd0) begin
                  produced    = 1'b1;
                  w.kind      = KIND_DONE;
                  w.status    = ST_OK;
                  w.atype     = hdr_type;
                  w.addr_high = addr_high;
                  w.addr_low  = addr_low;
                  w.port      = port_acc;
                  w.name_len  = dom_len;
                  w.consumed  = byte_count;
                  phase       = PHASE_IDLE;
               end
            end
            default: phase = PHASE_IDLE;
         endcase
      end
      if (faulted) begin
         produced = 1'b1;
         w        = '0;
         w.kind   = KIND_ERR;
         w.status = fault;
         w.atype  = hdr_type;
         phase    = PHASE_IDLE;
      end
   endtask

   // offer one word in bursts with random gaps, return once it is taken
   task automatic accept_word(input logic [7:0] d, input logic f, input logic [15:0] t);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left     = burst_left - 1;
      req_valid      = 1'b1;
      req_data_byte  = d;
      req_first_byte = f;
      req_total_len  = t;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_word(input logic [7:0] d, input logic f, input logic [15:0] t);
      bit              produced;
      header_word_type w;
      accept_word(d, f, t);
      decode_header_byte(d, f, t, produced, w);
      if (produced) due_results.push_back(w);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid  = 1'b0;
      burst_left = 0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_code(input logic [1:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (index)
         CSR_IPV4_CODE:   code_ipv4   = value;
         CSR_DOMAIN_CODE: code_domain = value;
         CSR_IPV6_CODE:   code_ipv6   = value;
         default: ;
      endcase
   endtask

   function automatic void add_row(input logic [7:0] d, input logic f, input logic [15:0] t,
                                   input bit typed, input logic [1:0] status,
                                   input logic [7:0] atype);
      stim_row_type row;
      row.data   = d;
      row.first  = f;
      row.total  = t;
      row.typed  = typed;
      row.status = status;
      row.atype  = atype;
      directed_rows.push_back(row);
   endfunction

   task automatic send_random_header(inout int counted);
      int          pick, body, cut, trail, i;
      bit          is_domain;
      logic [7:0]  type_byte, name_len, payload;
      logic [15:0] total;
      pick      = $urandom_range(0, 99);
      is_domain = 1'b0;
      name_len  = 8'd0;
      if (pick < 30) begin
         type_byte = code_ipv4;
         body      = 4;
      end else if (pick < 50) begin
         type_byte = code_ipv6;
         body      = 16;
      end else if (pick < 94) begin
         is_domain = 1'b1;
         type_byte = code_domain;
         case ($urandom_range(0, 39))
            0:       name_len = 8'd255;
            1:       name_len = 8'd0;
            default: name_len = 8'($urandom_range(1, 12));
         endcase
         body = 1 + int'(name_len);
      end else begin
         do type_byte = 8'($urandom_range(0, 255));
         while (type_byte == code_ipv4 || type_byte == code_ipv6 || type_byte == code_domain);
         body = 4;
      end
      cut   = body + 3;
      total = 16'(cut + $urandom_range(0, 3));
      case ($urandom_range(0, 11))
         0:       total = 16'hFFFF;
         1:       total = 16'($urandom_range(0, body + 2));
         2:       cut   = $urandom_range(1, body + 2);
         default: ;
      endcase
      send_word(type_byte, 1'b1, total);
      for (i = 1; i < cut; i++) begin
         payload = (is_domain && i == 1) ? name_len : 8'($urandom_range(0, 255));
         send_word(payload, 1'b0, 16'($urandom_range(0, 65535)));
      end
      counted += cut;
      if (cut == body + 3) begin
         trail = $urandom_range(0, 3);
         for (i = 0; i < trail; i++)
            send_word(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
      end
   endtask

   task automatic run_traffic(input int quota);
      int sent, i, noise;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(0, 19) == 0) begin
            noise = $urandom_range(1, 3);
            for (i = 0; i < noise; i++)
               send_word(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
         end
         send_random_header(sent);
      end
      // empty buffer returns the parser to idle
      send_word(8'h00, 1'b1, 16'd0);
      drain_results();
   endtask

   // receiver: stall on shifting patterns, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_asked != holds_done) begin
         holds_done = holds_done + 1;
         hold_left  = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left = $urandom_range(10, 80);
            case ($urandom_range(0, 4))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 25;
               3:       stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end
         mode_left = mode_left - 1;
         rsp_ready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [63:0] expected,
                              input logic [63:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0h, got %0h", name, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $error("result word with none expected: kind %0d, status %0d",
                   rsp_result_kind, rsp_status);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            check_field("result_kind",    64'(want.kind),      64'(rsp_result_kind));
            check_field("status",         64'(want.status),    64'(rsp_status));
            check_field("address_type",   64'(want.atype),     64'(rsp_address_type));
            check_field("address_high",   want.addr_high,      rsp_address_high);
            check_field("address_low",    want.addr_low,       rsp_address_low);
            check_field("port_number",    64'(want.port),      64'(rsp_port_number));
            check_field("name_length",    64'(want.name_len),  64'(rsp_name_length));
            check_field("bytes_consumed", 64'(want.consumed),  64'(rsp_bytes_consumed));
            check_field("name_byte",      64'(want.name_byte), 64'(rsp_name_byte));
         end
      end
   end

   initial begin : stimulus
      bit              produced;
      header_word_type w;
      logic [7:0]      shared_code;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = 8'd0;
      req_first_byte = 1'b0;
      req_total_len  = 16'd0;
      csr_we         = 1'b0;
      csr_index      = CSR_IPV4_CODE;
      csr_wdata      = 8'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty buffer, short IP buffers, missing length byte, unknown type
      add_row(8'hFF, 1'b1, 16'd0,    1'b1, ST_MALFORMED, 8'h00);
      add_row(8'h01, 1'b1, 16'd6,    1'b1, ST_MALFORMED, 8'h01);
      add_row(8'h04, 1'b1, 16'd18,   1'b1, ST_MALFORMED, 8'h04);
      add_row(8'h03, 1'b1, 16'd1,    1'b1, ST_MALFORMED, 8'h03);
      add_row(8'hFF, 1'b1, 16'hFFFF, 1'b1, ST_BADADDR,   8'hFF);
      add_row(8'h55, 1'b0, 16'hFFFF, 1'b0, ST_OK,        8'h00);
      // shortest IPv4 header
      add_row(8'h01, 1'b1, 16'd7,    1'b0, ST_OK,        8'h00);
      add_row(8'hFF, 1'b0, 16'd0,    1'b0, ST_OK,        8'h00);
      add_row(8'h00, 1'b0, 16'd0,    1'b0, ST_OK,        8'h00);
      add_row(8'hAA, 1'b0, 16'd0,    1'b0, ST_OK,        8'h00);
      add_row(8'h55, 1'b0, 16'd0,    1'b0, ST_OK,        8'h00);
      add_row(8'hFF, 1'b0, 16'd0,    1'b0, ST_OK,        8'h00);
      add_row(8'hFF, 1'b0, 16'd0,    1'b0, ST_OK,        8'h00);
      // zero domain length
      add_row(8'h03, 1'b1, 16'hFFFF, 1'b0, ST_OK,        8'h00);
      add_row(8'h00, 1'b0, 16'd0,    1'b1, ST_BADADDR,   8'h03);
      // domain longer than the buffer
      add_row(8'h03, 1'b1, 16'd5,    1'b0, ST_OK,        8'h00);
      add_row(8'h02, 1'b0, 16'd0,    1'b1, ST_BADADDR,   8'h03);
      // one-byte domain in an exact buffer
      add_row(8'h03, 1'b1, 16'd5,    1'b0, ST_OK,        8'h00);
      add_row(8'h01, 1'b0, 16'd0,    1'b0, ST_OK,        8'h00);
      add_row(8'h80, 1'b0, 16'd0,    1'b0, ST_OK,        8'h00);
      add_row(8'h00, 1'b0, 16'd0,    1'b0, ST_OK,        8'h00);
      add_row(8'h01, 1'b0, 16'd0,    1'b0, ST_OK,        8'h00);
      // new header drops an IPv6 one in progress
      add_row(8'h04, 1'b1, 16'd19,   1'b0, ST_OK,        8'h00);
      add_row(8'hC3, 1'b0, 16'd0,    1'b0, ST_OK,        8'h00);
      add_row(8'h00, 1'b1, 16'd1,    1'b1, ST_BADADDR,   8'h00);

      foreach (directed_rows[i]) begin
         accept_word(directed_rows[i].data, directed_rows[i].first, directed_rows[i].total);
         decode_header_byte(directed_rows[i].data, directed_rows[i].first,
                            directed_rows[i].total, produced, w);
         if (directed_rows[i].typed) begin
            w        = '0;
            w.kind   = KIND_ERR;
            w.status = directed_rows[i].status;
            w.atype  = directed_rows[i].atype;
            due_results.push_back(w);
         end else if (produced) begin
            due_results.push_back(w);
         end
      end
      drain_results();

      // default codes, with one long receiver hold-off
      hold_asked = hold_asked + 1;
      run_traffic(300);

      write_code(CSR_IPV4_CODE,   8'd0);
      write_code(CSR_DOMAIN_CODE, 8'd255);
      write_code(CSR_IPV6_CODE,   8'd128);
      run_traffic(300);

      // IPv4 and IPv6 share a code
      write_code(CSR_IPV4_CODE,   8'd255);
      write_code(CSR_DOMAIN_CODE, 8'd0);
      write_code(CSR_IPV6_CODE,   8'd255);
      run_traffic(300);

      // IPv6 and domain share a code
      shared_code = 8'($urandom_range(0, 255));
      write_code(CSR_IPV4_CODE,   8'($urandom_range(0, 255)));
      write_code(CSR_DOMAIN_CODE, shared_code);
      write_code(CSR_IPV6_CODE,   shared_code);
      run_traffic(300);

      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
